### src/pulse_distance_frame_decoder_macros.svh
// Assertion macros for the pulse-distance frame decoder checker.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef PULSE_DISTANCE_FRAME_DECODER_MACROS_SVH
`define PULSE_DISTANCE_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PDFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pdfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pulse-distance frame decoder.
// Used by every module of the block but pdfd_fifo; depends on nothing.
package pdfd_pkg;

	localparam int WIDTH_BITS = 20;
	localparam int FRAME_BITS = 40;
	localparam int POS_BITS   = 6;
	localparam int TIME_BITS  = WIDTH_BITS + 1;
	localparam int IDX_BITS   = 3;
	localparam int CMD_DEPTH  = 2;
	localparam int RES_DEPTH  = 2;

	localparam logic [IDX_BITS-1:0] REG_HDR_MARK_MIN  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_HDR_SPACE_MIN = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_MARK_MAX      = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_SPACE_ZERO    = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_SPACE_ONE     = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_TIMEOUT       = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_TIME_LIMIT    = 3'd6;

	localparam logic [WIDTH_BITS-1:0] RST_HDR_MARK_MIN  = 20'd7000;
	localparam logic [WIDTH_BITS-1:0] RST_HDR_SPACE_MIN = 20'd3000;
	localparam logic [WIDTH_BITS-1:0] RST_MARK_MAX      = 20'd500;
	localparam logic [WIDTH_BITS-1:0] RST_SPACE_ZERO    = 20'd600;
	localparam logic [WIDTH_BITS-1:0] RST_SPACE_ONE     = 20'd1500;
	localparam logic [WIDTH_BITS-1:0] RST_TIMEOUT       = 20'd50000;
	localparam logic [WIDTH_BITS-1:0] RST_TIME_LIMIT    = 20'd70000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EARLY = 2'd1;
	localparam logic [1:0] ST_SLOW  = 2'd2;

	typedef struct packed {
		logic                  line_level;
		logic [WIDTH_BITS-1:0] pulse_width;
	} pulse_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [7:0]            temperature;
		logic [7:0]            water_level;
		logic [FRAME_BITS-1:0] raw_frame;
		logic [POS_BITS-1:0]   bits_received;
	} result_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] header_mark_min;
		logic [WIDTH_BITS-1:0] header_space_min;
		logic [WIDTH_BITS-1:0] mark_max;
		logic [WIDTH_BITS-1:0] space_zero_max;
		logic [WIDTH_BITS-1:0] space_one_max;
		logic [WIDTH_BITS-1:0] pulse_timeout;
		logic [WIDTH_BITS-1:0] frame_time_limit;
	} cfg_t;

	// classified pulse handed from front to back
	typedef struct packed {
		logic                  level;
		logic [WIDTH_BITS-1:0] raw;
		logic                  timed_out;
		logic                  raw_zero;
		logic                  gt_hdr_mark;
		logic                  gt_hdr_space;
		logic                  lt_mark_max;
		logic                  mark_max_nz;
		logic                  lt_space_zero;
		logic                  lt_space_one;
	} class_t;

endpackage

### src/pulse_distance_frame_decoder.sv
`timescale 1ns / 1ps
// Pulse-distance frame decoder top level: config registers, front, queues, back.
// A frame-ending request is registered in the command queue; the back then writes its result into the result queue.
// Throughput: one pulse per cycle; the back stalls only while the result queue is full.
// Reset: arst_n clears queues and frame state and loads default thresholds.
// Depends on pdfd_pkg, pdfd_fifo, pdfd_front, pdfd_back.
module pulse_distance_frame_decoder #(
	parameter int CMD_DEPTH = pdfd_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = pdfd_pkg::RES_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  pdfd_pkg::pulse_t                    pulse,
	output logic                                empty,
	input  logic                                pop,
	output pdfd_pkg::result_t                   result,
	input  logic                                wr_en,
	input  logic [pdfd_pkg::IDX_BITS-1:0]       wr_index,
	input  logic [pdfd_pkg::WIDTH_BITS-1:0]     wr_data
);
	pdfd_pkg::cfg_t    cfg_q;
	pdfd_pkg::class_t  cls_in, cls_out;
	pdfd_pkg::result_t res;
	logic              cls_empty, cls_pop, res_full, res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_mark_min  <= pdfd_pkg::RST_HDR_MARK_MIN;
			cfg_q.header_space_min <= pdfd_pkg::RST_HDR_SPACE_MIN;
			cfg_q.mark_max         <= pdfd_pkg::RST_MARK_MAX;
			cfg_q.space_zero_max   <= pdfd_pkg::RST_SPACE_ZERO;
			cfg_q.space_one_max    <= pdfd_pkg::RST_SPACE_ONE;
			cfg_q.pulse_timeout    <= pdfd_pkg::RST_TIMEOUT;
			cfg_q.frame_time_limit <= pdfd_pkg::RST_TIME_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				pdfd_pkg::REG_HDR_MARK_MIN:  cfg_q.header_mark_min  <= wr_data;
				pdfd_pkg::REG_HDR_SPACE_MIN: cfg_q.header_space_min <= wr_data;
				pdfd_pkg::REG_MARK_MAX:      cfg_q.mark_max         <= wr_data;
				pdfd_pkg::REG_SPACE_ZERO:    cfg_q.space_zero_max   <= wr_data;
				pdfd_pkg::REG_SPACE_ONE:     cfg_q.space_one_max    <= wr_data;
				pdfd_pkg::REG_TIMEOUT:       cfg_q.pulse_timeout    <= wr_data;
				pdfd_pkg::REG_TIME_LIMIT:    cfg_q.frame_time_limit <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pdfd_front u_front (
		.cfg   (cfg_q),
		.pulse (pulse),
		.cls   (cls_in)
	);

	pdfd_fifo #(
		.WIDTH ($bits(pdfd_pkg::class_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (cls_pop),
		.rdata  (cls_out),
		.empty  (cls_empty)
	);

	pdfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.time_limit (cfg_q.frame_time_limit),
		.cls        (cls_out),
		.cls_empty  (cls_empty),
		.cls_pop    (cls_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	pdfd_fifo #(
		.WIDTH ($bits(pdfd_pkg::result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

### src/pdfd_fifo.sv
`timescale 1ns / 1ps
// Small register queue with show-ahead read, used between decoder stages.
// Depends on nothing.
module pdfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_ok, rd_ok;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign wr_ok = push && !full;
	assign rd_ok = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_ok, rd_ok})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### src/pdfd_front.sv
`timescale 1ns / 1ps
// Front of the decoder: compares each pulse width against the thresholds.
// Depends on pdfd_pkg.
module pdfd_front (
	input  pdfd_pkg::cfg_t   cfg,
	input  pdfd_pkg::pulse_t pulse,
	output pdfd_pkg::class_t cls
);
	always_comb begin
		cls.level         = pulse.line_level;
		cls.raw           = pulse.pulse_width;
		cls.timed_out     = pulse.pulse_width > cfg.pulse_timeout;
		cls.raw_zero      = pulse.pulse_width == '0;
		cls.gt_hdr_mark   = pulse.pulse_width > cfg.header_mark_min;
		cls.gt_hdr_space  = pulse.pulse_width > cfg.header_space_min;
		cls.lt_mark_max   = pulse.pulse_width < cfg.mark_max;
		cls.mark_max_nz   = cfg.mark_max != '0;
		cls.lt_space_zero = pulse.pulse_width < cfg.space_zero_max;
		cls.lt_space_one  = pulse.pulse_width < cfg.space_one_max;
	end

endmodule

### src/pdfd_back.sv
`timescale 1ns / 1ps
// Back of the decoder: frame state machine, bit assembly and time budget.
// Depends on pdfd_pkg.
module pdfd_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pdfd_pkg::WIDTH_BITS-1:0]      time_limit,
	input  pdfd_pkg::class_t                     cls,
	input  logic                                 cls_empty,
	output logic                                 cls_pop,
	input  logic                                 res_full,
	output logic                                 res_push,
	output pdfd_pkg::result_t                    res
);
	localparam int TB = pdfd_pkg::TIME_BITS;
	localparam int FB = pdfd_pkg::FRAME_BITS;
	localparam int PB = pdfd_pkg::POS_BITS;

	typedef enum logic [1:0] {PH_IDLE, PH_HDR_SPACE, PH_MARK, PH_SPACE} phase_t;

	phase_t          phase_q, phase_nx;
	logic [PB-1:0]   pos_q, pos_nx, done;
	logic [FB-1:0]   frame_q, frame_nx;
	logic [TB-1:0]   elapsed_q, elapsed_nx, base;
	logic [TB:0]     sum;
	logic            expect_hi, wz, fin;
	logic [1:0]      st;
	logic [PB-1:0]   cnt;

	assign cls_pop   = !cls_empty && !res_full;
	assign expect_hi = (phase_q == PH_IDLE) || (phase_q == PH_MARK);
	assign wz        = cls.timed_out || cls.raw_zero || (cls.level != expect_hi);
	assign done      = PB'(FB - 1) - pos_q;
	assign base      = (phase_q == PH_IDLE) ? '0 : elapsed_q;
	assign sum       = {1'b0, base} + (TB + 1)'(cls.raw);
	assign elapsed_nx = sum[TB] ? '1 : sum[TB-1:0];

	always_comb begin
		phase_nx = phase_q;
		pos_nx   = pos_q;
		frame_nx = frame_q;
		fin      = 1'b0;
		st       = pdfd_pkg::ST_EARLY;
		cnt      = done;
		unique case (phase_q)
			PH_IDLE: begin
				frame_nx = '0;
				pos_nx   = PB'(FB - 1);
				if (!wz && cls.gt_hdr_mark) begin
					phase_nx = PH_HDR_SPACE;
				end
			end
			PH_HDR_SPACE: begin
				phase_nx = (!wz && cls.gt_hdr_space) ? PH_MARK : PH_IDLE;
			end
			PH_MARK: begin
				if (wz ? cls.mark_max_nz : cls.lt_mark_max) begin
					phase_nx = PH_SPACE;
				end else begin
					fin = 1'b1;
				end
			end
			PH_SPACE: begin
				if (wz || (!cls.lt_space_zero && !cls.lt_space_one)) begin
					fin = 1'b1;
				end else begin
					if (!cls.lt_space_zero) begin
						frame_nx = frame_q | (FB'(1) << pos_q);
					end
					if (pos_q == '0) begin
						fin = 1'b1;
						st  = pdfd_pkg::ST_OK;
						cnt = PB'(FB);
					end else begin
						pos_nx   = pos_q - 1'b1;
						phase_nx = PH_MARK;
					end
				end
			end
			default: phase_nx = PH_IDLE;
		endcase
		if (fin) begin
			phase_nx = PH_IDLE;
		end
	end

	assign res_push          = cls_pop && fin;
	assign res.status        = (elapsed_nx >= {1'b0, time_limit}) ? pdfd_pkg::ST_SLOW : st;
	assign res.temperature   = frame_nx[31:24];
	assign res.water_level   = frame_nx[23:16];
	assign res.raw_frame     = frame_nx;
	assign res.bits_received = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= PB'(FB - 1);
			frame_q   <= '0;
			elapsed_q <= '0;
		end else if (cls_pop) begin
			phase_q   <= phase_nx;
			pos_q     <= pos_nx;
			frame_q   <= frame_nx;
			elapsed_q <= elapsed_nx;
		end
	end

endmodule

### src/pdfd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the pulse-distance frame decoder, bound to the top level.
// Depends on pdfd_pkg and pulse_distance_frame_decoder_macros.svh.
`include "pulse_distance_frame_decoder_macros.svh"

module pdfd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input pdfd_pkg::result_t result
);
	`PDFD_ASSERT_NOW(a_status_code, !empty, result.status != 2'd3, "status code out of range")
	`PDFD_ASSERT_NOW(a_count_range, !empty, result.bits_received <= 6'(pdfd_pkg::FRAME_BITS), "bit count too large")
	`PDFD_ASSERT_NOW(a_full_frame, !empty && (result.status == pdfd_pkg::ST_OK), result.bits_received == 6'(pdfd_pkg::FRAME_BITS), "complete frame with short count")
	`PDFD_ASSERT_NOW(a_bytes, !empty, (result.temperature == result.raw_frame[31:24]) && (result.water_level == result.raw_frame[23:16]), "bytes disagree with frame")
	`PDFD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

bind pulse_distance_frame_decoder pdfd_checker u_pdfd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

### dv/pulse_distance_frame_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pulse-distance frame decoder: directed and random pulse
// trains under several register settings, checked against an in-bench frame predictor.
// Depends on pdfd_pkg and pulse_distance_frame_decoder.
module pulse_distance_frame_decoder_test;

	localparam int WMAX = (1 << pdfd_pkg::WIDTH_BITS) - 1;
	localparam logic [pdfd_pkg::TIME_BITS:0] TIME_MAX = {1'b0, {pdfd_pkg::TIME_BITS{1'b1}}};
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {HUNT_MARK, HUNT_SPACE, DATA_MARK, DATA_SPACE} decode_phase_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            push = 1'b0;
	logic                            full;
	pdfd_pkg::pulse_t                pulse = '0;
	logic                            empty;
	logic                            pop = 1'b0;
	pdfd_pkg::result_t               result;
	logic                            wr_en = 1'b0;
	logic [pdfd_pkg::IDX_BITS-1:0]   wr_index = '0;
	logic [pdfd_pkg::WIDTH_BITS-1:0] wr_data = '0;

	pdfd_pkg::pulse_t  pulses_to_send[$];
	pdfd_pkg::result_t frame_reports[$];
	int                queued_items = 0;
	int                error_count = 0;
	int                cycle_count = 0;
	int                gap_left = 0;
	bit                drive_burst = 1'b0;
	int                stall_left = 0;
	bit                pop_burst = 1'b0;
	pdfd_pkg::result_t want;

	pdfd_pkg::cfg_t                  cfg;
	decode_phase_t                   dec_phase = HUNT_MARK;
	logic [pdfd_pkg::POS_BITS-1:0]   dec_pos = pdfd_pkg::POS_BITS'(pdfd_pkg::FRAME_BITS - 1);
	logic [pdfd_pkg::FRAME_BITS-1:0] dec_bits = '0;
	logic [pdfd_pkg::TIME_BITS-1:0]  dec_time = '0;

	pulse_distance_frame_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pulse    (pulse),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task close_frame(input logic [1:0] st, input logic [pdfd_pkg::POS_BITS-1:0] count);
		pdfd_pkg::result_t r;
		r.status        = (dec_time >= cfg.frame_time_limit) ? pdfd_pkg::ST_SLOW : st;
		r.temperature   = dec_bits[31:24];
		r.water_level   = dec_bits[23:16];
		r.raw_frame     = dec_bits;
		r.bits_received = count;
		frame_reports.push_back(r);
		dec_phase = HUNT_MARK;
	endtask

	task decode_pulse(input pdfd_pkg::pulse_t p);
		logic                            expect_high;
		logic [pdfd_pkg::WIDTH_BITS-1:0] w;
		logic [pdfd_pkg::POS_BITS-1:0]   done;
		logic [pdfd_pkg::TIME_BITS-1:0]  base;
		logic [pdfd_pkg::TIME_BITS:0]    sum;
		expect_high = (dec_phase == HUNT_MARK || dec_phase == DATA_MARK);
		w = p.pulse_width;
		if (w > cfg.pulse_timeout || p.line_level != expect_high)
			w = '0;
		done = pdfd_pkg::POS_BITS'(pdfd_pkg::FRAME_BITS - 1) - dec_pos;
		base = (dec_phase == HUNT_MARK) ? '0 : dec_time;
		sum = base;
		sum = sum + p.pulse_width;
		dec_time = (sum > TIME_MAX) ? '1 : sum[pdfd_pkg::TIME_BITS-1:0];
		case (dec_phase)
			HUNT_MARK: begin
				dec_bits = '0;
				dec_pos = pdfd_pkg::POS_BITS'(pdfd_pkg::FRAME_BITS - 1);
				if (w > cfg.header_mark_min)
					dec_phase = HUNT_SPACE;
			end
			HUNT_SPACE: begin
				dec_phase = (w > cfg.header_space_min) ? DATA_MARK : HUNT_MARK;
			end
			DATA_MARK: begin
				if (w < cfg.mark_max)
					dec_phase = DATA_SPACE;
				else
					close_frame(pdfd_pkg::ST_EARLY, done);
			end
			default: begin
				if (w == 0 || (w >= cfg.space_zero_max && w >= cfg.space_one_max)) begin
					close_frame(pdfd_pkg::ST_EARLY, done);
				end else begin
					if (w >= cfg.space_zero_max)
						dec_bits[dec_pos] = 1'b1;
					if (dec_pos == 0) begin
						close_frame(pdfd_pkg::ST_OK,
							pdfd_pkg::POS_BITS'(pdfd_pkg::FRAME_BITS));
					end else begin
						dec_pos = dec_pos - 1'b1;
						dec_phase = DATA_MARK;
					end
				end
			end
		endcase
	endtask

	task check_field(input string name, input logic [63:0] exp_val, input logic [63:0] got);
		if (exp_val !== got) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch in %s: expected %0h, got %0h", name, exp_val, got);
		end
	endtask

	// pulse driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			gap_left = 0;
		end else begin
			if (push && !full)
				decode_pulse(pulse);
			if (push && full) begin
				// hold the request
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pulses_to_send.size() != 0) begin
				pulse <= pulses_to_send.pop_front();
				push <= 1'b1;
				gap_left = drive_burst ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 29) == 0)
					drive_burst = !drive_burst;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left = 0;
		end else begin
			if (pop && !empty) begin
				if (frame_reports.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: %p", result);
				end else begin
					want = frame_reports.pop_front();
					check_field("status", want.status, result.status);
					check_field("temperature", want.temperature, result.temperature);
					check_field("water_level", want.water_level, result.water_level);
					check_field("raw_frame", want.raw_frame, result.raw_frame);
					check_field("bits_received", want.bits_received, result.bits_received);
				end
				stall_left = pop_burst ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 29) == 0)
					pop_burst = !pop_burst;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("pulse_distance_frame_decoder_test: FAIL");
			$finish;
		end
	end

	function automatic int pick_width(int lo, int hi);
		if (hi > WMAX)
			hi = WMAX;
		if (lo > WMAX)
			lo = WMAX;
		if (hi <= lo)
			return lo;
		if ($urandom_range(0, 7) != 0 && hi > lo + 2000)
			hi = lo + 2000;
		return $urandom_range(lo, hi);
	endfunction

	task add_pulse(input bit level, input int width, input bit corrupt);
		pdfd_pkg::pulse_t p;
		if (corrupt && $urandom_range(0, 39) == 0)
			level = !level;
		if (corrupt && $urandom_range(0, 49) == 0)
			width = pick_width(int'(cfg.pulse_timeout) + 1, WMAX);
		p.line_level = level;
		p.pulse_width = pdfd_pkg::WIDTH_BITS'(width);
		pulses_to_send.push_back(p);
		queued_items++;
	endtask

	task queue_frame();
		int tmo;
		int nbits;
		int ending;
		int mark_hi;
		int zero_hi;
		int one_lo;
		int one_hi;
		tmo = int'(cfg.pulse_timeout);
		mark_hi = (int'(cfg.mark_max) - 1 < tmo) ? int'(cfg.mark_max) - 1 : tmo;
		zero_hi = (int'(cfg.space_zero_max) - 1 < tmo) ? int'(cfg.space_zero_max) - 1 : tmo;
		one_lo = (cfg.space_zero_max > 0) ? int'(cfg.space_zero_max) : 1;
		one_hi = (int'(cfg.space_one_max) - 1 < tmo) ? int'(cfg.space_one_max) - 1 : tmo;
		nbits = ($urandom_range(0, 1) == 0) ? pdfd_pkg::FRAME_BITS :
			$urandom_range(0, pdfd_pkg::FRAME_BITS - 1);
		add_pulse(1'b1, pick_width(int'(cfg.header_mark_min) + 1, tmo), 1'b1);
		add_pulse(1'b0, pick_width(int'(cfg.header_space_min) + 1, tmo), 1'b1);
		for (int i = 0; i < nbits; i++) begin
			add_pulse(1'b1, pick_width(0, mark_hi), 1'b1);
			if ($urandom_range(0, 1) == 0)
				add_pulse(1'b0, pick_width(1, zero_hi), 1'b1);
			else
				add_pulse(1'b0, pick_width(one_lo, one_hi), 1'b1);
		end
		if (nbits < pdfd_pkg::FRAME_BITS) begin
			ending = $urandom_range(0, 3);
			if (ending == 0) begin
				add_pulse(1'b1, pick_width(int'(cfg.mark_max), tmo), 1'b0);
			end else if (ending == 1) begin
				add_pulse(1'b1, pick_width(0, mark_hi), 1'b0);
				add_pulse(1'b0, 0, 1'b0);
			end else if (ending == 2) begin
				add_pulse(1'b1, pick_width(0, mark_hi), 1'b0);
				add_pulse(1'b0, pick_width(int'(cfg.space_one_max), tmo), 1'b0);
			end
		end
	endtask

	task random_traffic();
		int start_items;
		int frames;
		start_items = queued_items;
		frames = 0;
		while (queued_items - start_items < 180 || frames < 3) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 4))
					add_pulse($urandom_range(0, 1),
						($urandom_range(0, 1) == 0) ? int'($urandom & WMAX) : pick_width(0, 20000),
						1'b0);
			end else begin
				queue_frame();
				frames++;
			end
		end
	endtask

	task wait_drained(input int settle);
		do
			@(negedge clk);
		while (pulses_to_send.size() != 0 || push || frame_reports.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task write_reg(input logic [pdfd_pkg::IDX_BITS-1:0] idx,
		input logic [pdfd_pkg::WIDTH_BITS-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
	endtask

	task load_config(input pdfd_pkg::cfg_t c);
		write_reg(pdfd_pkg::REG_HDR_MARK_MIN, c.header_mark_min);
		write_reg(pdfd_pkg::REG_HDR_SPACE_MIN, c.header_space_min);
		write_reg(pdfd_pkg::REG_MARK_MAX, c.mark_max);
		write_reg(pdfd_pkg::REG_SPACE_ZERO, c.space_zero_max);
		write_reg(pdfd_pkg::REG_SPACE_ONE, c.space_one_max);
		write_reg(pdfd_pkg::REG_TIMEOUT, c.pulse_timeout);
		write_reg(pdfd_pkg::REG_TIME_LIMIT, c.frame_time_limit);
		@(posedge clk);
		wr_en <= 1'b0;
		cfg = c;
		@(negedge clk);
	endtask

	initial begin
		pdfd_pkg::cfg_t c;
		cfg = '{pdfd_pkg::RST_HDR_MARK_MIN, pdfd_pkg::RST_HDR_SPACE_MIN,
			pdfd_pkg::RST_MARK_MAX, pdfd_pkg::RST_SPACE_ZERO, pdfd_pkg::RST_SPACE_ONE,
			pdfd_pkg::RST_TIMEOUT, pdfd_pkg::RST_TIME_LIMIT};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// header mark timed out, wrong level, header space of wrong level
		add_pulse(1'b1, WMAX, 1'b0);
		add_pulse(1'b0, 9000, 1'b0);
		add_pulse(1'b1, 9000, 1'b0);
		add_pulse(1'b1, 4500, 1'b0);
		// two bits then a long mark
		add_pulse(1'b1, 9000, 1'b0);
		add_pulse(1'b0, 4500, 1'b0);
		add_pulse(1'b1, 300, 1'b0);
		add_pulse(1'b0, 1000, 1'b0);
		add_pulse(1'b1, 0, 1'b0);
		add_pulse(1'b0, 400, 1'b0);
		add_pulse(1'b1, 600, 1'b0);
		// zero-width space, then overlong space
		add_pulse(1'b1, 9000, 1'b0);
		add_pulse(1'b0, 4500, 1'b0);
		add_pulse(1'b1, 300, 1'b0);
		add_pulse(1'b0, 0, 1'b0);
		add_pulse(1'b1, 9000, 1'b0);
		add_pulse(1'b0, 4500, 1'b0);
		add_pulse(1'b1, 300, 1'b0);
		add_pulse(1'b0, 2000, 1'b0);
		// header past timeout, then a frame over the time limit
		add_pulse(1'b1, 60000, 1'b0);
		add_pulse(1'b1, 49000, 1'b0);
		add_pulse(1'b0, 30000, 1'b0);
		add_pulse(1'b1, 300, 1'b0);
		add_pulse(1'b0, 400, 1'b0);
		add_pulse(1'b1, 700, 1'b0);
		random_traffic();
		wait_drained(8);

		load_config(cfg);
		random_traffic();
		wait_drained(8);

		load_config('0);
		random_traffic();
		wait_drained(8);

		load_config('1);
		random_traffic();
		wait_drained(8);

		c = '1;
		c.header_mark_min = '0;
		c.header_space_min = '0;
		c.space_zero_max = pdfd_pkg::WIDTH_BITS'($urandom_range(1, 3000));
		load_config(c);
		random_traffic();
		wait_drained(8);

		c = '{20'd100, 20'd50, 20'd20, 20'd30, 20'd60, 20'd200,
			pdfd_pkg::WIDTH_BITS'($urandom_range(500, 5000))};
		load_config(c);
		random_traffic();
		wait_drained(8);

		repeat (2) begin
			c.header_mark_min = pdfd_pkg::WIDTH_BITS'($urandom_range(0, 20000));
			c.header_space_min = pdfd_pkg::WIDTH_BITS'($urandom_range(0, 10000));
			c.mark_max = pdfd_pkg::WIDTH_BITS'($urandom_range(0, 2000));
			c.space_zero_max = pdfd_pkg::WIDTH_BITS'($urandom_range(0, 2000));
			c.space_one_max = pdfd_pkg::WIDTH_BITS'($urandom_range(0, 4000));
			c.pulse_timeout = pdfd_pkg::WIDTH_BITS'($urandom & WMAX);
			c.frame_time_limit = pdfd_pkg::WIDTH_BITS'($urandom & WMAX);
			load_config(c);
			random_traffic();
			wait_drained(8);
		end

		repeat (20) @(negedge clk);
		error_count += frame_reports.size();
		if (error_count == 0)
			$display("pulse_distance_frame_decoder_test: PASS");
		else
			$display("pulse_distance_frame_decoder_test: FAIL");
		$finish;
	end

endmodule
